FILE: rtl/core/frame_peak_amplitude_extractor_top_macros.svh
// Assertion macros shared by the checker of the frame peak amplitude extractor.
`ifndef FRAME_PEAK_AMPLITUDE_EXTRACTOR_TOP_MACROS_SVH
`define FRAME_PEAK_AMPLITUDE_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fpae_pkg.sv
// Package with the widths, types and register codes of the frame peak amplitude extractor.
package fpae_pkg;

	localparam int CHANNELS    = 2;
	localparam int CH_W        = 1;
	localparam int SAMPLE_W    = 16;
	localparam int MAG_W       = 16;
	localparam int TIME_W      = 32;
	localparam int RATE_W      = 18;
	localparam int LEN_W       = 16;
	localparam int CIU_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 18;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0]  FRAME_SAMPLES_RST   = LEN_W'(4410);
	localparam logic [RATE_W-1:0] SAMPLE_RATE_RST     = RATE_W'(44100);
	localparam logic [CIU_W-1:0]  CHANNELS_IN_USE_RST = CIU_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN_ENABLE      = 2'd0,
		REG_FRAME_SAMPLES   = 2'd1,
		REG_SAMPLE_RATE     = 2'd2,
		REG_CHANNELS_IN_USE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              run_enable;
		logic [LEN_W-1:0]  frame_samples;
		logic [RATE_W-1:0] sample_rate;
		logic [CIU_W-1:0]  channels_in_use;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [MAG_W-1:0] mag;
	} q_item_t;

endpackage

FILE: rtl/core/fpae_in_if.sv
// Input channel carrying one tagged PCM sample per item.
interface fpae_in_if;
	import fpae_pkg::*;

	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

FILE: rtl/core/fpae_out_if.sv
// Result channel carrying one completed frame per item.
interface fpae_out_if;
	import fpae_pkg::*;

	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   out_channel;
	logic [MAG_W-1:0]  peak;
	logic [TIME_W-1:0] start_time;
	logic [RATE_W-1:0] time_unit;
	logic [LEN_W-1:0]  frame_length;

	modport source (output valid, output out_channel, output peak, output start_time,
		output time_unit, output frame_length, input ready);
	modport sink (input valid, input out_channel, input peak, input start_time,
		input time_unit, input frame_length, output ready);
endinterface

FILE: rtl/core/fpae_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface fpae_cfg_if;
	import fpae_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/frame_peak_amplitude_extractor_top.sv
// Top level of the frame peak amplitude extractor.
// The block takes one sample per clock cycle on its sample channel while its queue is not full
// and reports the peak magnitude of every completed frame of each channel on its result channel.
// A result is offered once the last sample of its frame has been accepted: the accepting edge
// writes the four-entry queue, and the frame engine, whose read-modify-write of the per-channel
// peak, count and total sets the rate, pops that sample and loads the result register. While a
// result waits to be taken the frame engine pops nothing, so the next samples flow only into the
// queue; the queue absorbs short stalls.
// Configuration writes are always taken and should be made while no sample is in flight;
// writing 1 to run_enable clears all totals and partial frames.
module frame_peak_amplitude_extractor_top (
	input logic        clk,
	input logic        arst_n,
	fpae_in_if.sink    smp,
	fpae_out_if.source res,
	fpae_cfg_if.sink   cfg
);
	import fpae_pkg::*;

	cfg_t    cfg_q;
	logic    clear;
	logic    push;
	logic    pop;
	logic    q_empty;
	logic    q_full;
	q_item_t push_item;
	q_item_t head;

	assign cfg.ready = 1'b1;
	assign clear = cfg.valid && cfg.ready
		&& (cfg_reg_t'(cfg.index) == REG_RUN_ENABLE) && cfg.data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_enable      <= 1'b0;
			cfg_q.frame_samples   <= FRAME_SAMPLES_RST;
			cfg_q.sample_rate     <= SAMPLE_RATE_RST;
			cfg_q.channels_in_use <= CHANNELS_IN_USE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_RUN_ENABLE:      cfg_q.run_enable      <= cfg.data[0];
				REG_FRAME_SAMPLES:   cfg_q.frame_samples   <= cfg.data[LEN_W-1:0];
				REG_SAMPLE_RATE:     cfg_q.sample_rate     <= cfg.data[RATE_W-1:0];
				REG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg.data[CIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fpae_front u_front (
		.smp       (smp),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	fpae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	fpae_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.clear  (clear),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.res    (res)
	);
endmodule

FILE: rtl/core/fpae_front.sv
// Front end: accepts samples, drops inactive ones and forms the magnitude for the queue.
module fpae_front (
	fpae_in_if.sink         smp,
	input  fpae_pkg::cfg_t  cfg,
	input  logic            q_full,
	output logic            push,
	output fpae_pkg::q_item_t push_item
);
	import fpae_pkg::*;

	logic keep;
	logic [SAMPLE_W-1:0] raw;

	assign raw = smp.sample;
	assign smp.ready = !q_full;

	assign keep = cfg.run_enable
		&& (CIU_W'(smp.channel) < cfg.channels_in_use)
		&& (32'(smp.channel) < CHANNELS);

	assign push = smp.valid && smp.ready && keep;

	always_comb begin
		push_item.ch = smp.channel;
		if (raw[SAMPLE_W-1]) begin
			push_item.mag = MAG_W'(~raw + SAMPLE_W'(1));
		end else begin
			push_item.mag = MAG_W'(raw);
		end
	end
endmodule

FILE: rtl/core/fpae_queue.sv
// Short first-in first-out queue between the front end and the frame engine.
module fpae_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fpae_pkg::q_item_t push_item,
	input  logic              pop,
	output fpae_pkg::q_item_t head,
	output logic              empty,
	output logic              full
);
	import fpae_pkg::*;

	q_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

FILE: rtl/core/fpae_back.sv
// Frame engine: per-channel peak, count and total, with the registered result stage.
module fpae_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fpae_pkg::cfg_t    cfg,
	input  logic              clear,
	input  fpae_pkg::q_item_t head,
	input  logic              empty,
	output logic              pop,
	fpae_out_if.source        res
);
	import fpae_pkg::*;

	logic [MAG_W-1:0]  peak_q  [CHANNELS];
	logic [LEN_W-1:0]  count_q [CHANNELS];
	logic [TIME_W-1:0] total_q [CHANNELS];

	logic              res_valid_q;
	logic [CH_W-1:0]   res_ch_q;
	logic [MAG_W-1:0]  res_peak_q;
	logic [TIME_W-1:0] res_start_q;
	logic [RATE_W-1:0] res_rate_q;
	logic [LEN_W-1:0]  res_len_q;

	logic [MAG_W-1:0]  cur_peak;
	logic [MAG_W-1:0]  new_peak;
	logic [LEN_W:0]    new_count;
	logic [LEN_W-1:0]  len;
	logic              done;

	assign pop = !empty && (!res_valid_q || res.ready);

	assign cur_peak  = peak_q[head.ch];
	assign new_peak  = (head.mag > cur_peak) ? head.mag : cur_peak;
	assign new_count = {1'b0, count_q[head.ch]} + (LEN_W + 1)'(1);
	assign len       = (cfg.frame_samples == '0) ? LEN_W'(1) : cfg.frame_samples;
	assign done      = (new_count >= {1'b0, len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				peak_q[c]  <= '0;
				count_q[c] <= '0;
				total_q[c] <= '0;
			end
		end else if (clear) begin
			for (int c = 0; c < CHANNELS; c++) begin
				peak_q[c]  <= '0;
				count_q[c] <= '0;
				total_q[c] <= '0;
			end
		end else if (pop) begin
			if (done) begin
				peak_q[head.ch]  <= '0;
				count_q[head.ch] <= '0;
				total_q[head.ch] <= total_q[head.ch] + TIME_W'(len);
			end else begin
				peak_q[head.ch]  <= new_peak;
				count_q[head.ch] <= new_count[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && done) begin
			res_ch_q    <= head.ch;
			res_peak_q  <= new_peak;
			res_start_q <= total_q[head.ch];
			res_rate_q  <= cfg.sample_rate;
			res_len_q   <= len;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.out_channel  = res_ch_q;
	assign res.peak         = res_peak_q;
	assign res.start_time   = res_start_q;
	assign res.time_unit    = res_rate_q;
	assign res.frame_length = res_len_q;
endmodule

FILE: rtl/core/fpae_checker.sv
// Port-level checker of the frame peak amplitude extractor and its bind to the top level.
`include "frame_peak_amplitude_extractor_top_macros.svh"

module fpae_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [fpae_pkg::MAG_W-1:0]    res_peak,
	input logic [fpae_pkg::TIME_W-1:0]   res_start_time,
	input logic [fpae_pkg::LEN_W-1:0]    res_frame_length
);
	import fpae_pkg::*;

	`FPAE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result withdrawn while stalled")
	`FPAE_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_peak) && $stable(res_start_time) && $stable(res_frame_length), "result changed while stalled")
	`FPAE_ASSERT_NOW(a_peak_range, clk, arst_n, res_valid, res_peak <= MAG_W'(32768), "peak above full-scale magnitude")
	`FPAE_ASSERT_NOW(a_len_nonzero, clk, arst_n, res_valid, res_frame_length != '0, "result reports an empty frame")
endmodule

bind frame_peak_amplitude_extractor_top fpae_checker u_fpae_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_peak         (res.peak),
	.res_start_time   (res.start_time),
	.res_frame_length (res.frame_length)
);

FILE: tb/tb_frame_peak_amplitude_extractor_top.sv
// Self-checking testbench for the frame peak amplitude extractor, with its own frame predictor.
`timescale 1ns / 1ps

module tb_frame_peak_amplitude_extractor_top;
	import fpae_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] s;
	} pcm_item_t;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [MAG_W-1:0]  peak;
		logic [TIME_W-1:0] start;
		logic [RATE_W-1:0] unit;
		logic [LEN_W-1:0]  len;
	} frame_rec_t;

	logic clk;
	logic arst_n;

	fpae_in_if  smp();
	fpae_out_if res();
	fpae_cfg_if cfg();

	frame_peak_amplitude_extractor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	pcm_item_t  pend[$];
	frame_rec_t frames_due[$];

	logic              cfg_run    = 1'b0;
	logic [LEN_W-1:0]  cfg_len    = FRAME_SAMPLES_RST;
	logic [RATE_W-1:0] cfg_rate   = SAMPLE_RATE_RST;
	logic [CIU_W-1:0]  cfg_active = CHANNELS_IN_USE_RST;

	logic [MAG_W-1:0]  peak_hold[CHANNELS];
	logic [LEN_W:0]    fill[CHANNELS];
	logic [TIME_W-1:0] elapsed[CHANNELS];

	logic idle_on   = 1'b1;
	logic smp_taken = 1'b0;
	int   smp_gap   = 0;
	int   res_stall = 0;
	int   errors       = 0;
	int   results_seen = 0;
	int   items_sent   = 0;
	int   writes_done  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(100_000_000);
		$display("Run timed out with %0d frame results outstanding", frames_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (errors < 40)
			$display("ERROR at %0t: %s", $time, what);
		errors++;
	endtask

	task automatic clear_progress();
		for (int c = 0; c < CHANNELS; c++) begin
			peak_hold[c] = '0;
			fill[c]      = '0;
			elapsed[c]   = '0;
		end
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (cfg_reg_t'(idx))
			REG_RUN_ENABLE: begin
				cfg_run = d[0];
				if (d[0])
					clear_progress();
			end
			REG_FRAME_SAMPLES:   cfg_len    = d[LEN_W-1:0];
			REG_SAMPLE_RATE:     cfg_rate   = d[RATE_W-1:0];
			REG_CHANNELS_IN_USE: cfg_active = d[CIU_W-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		logic [MAG_W-1:0] mag;
		logic [LEN_W-1:0] len;
		frame_rec_t       rec;
		if (!cfg_run || int'(ch) >= int'(cfg_active) || int'(ch) >= CHANNELS)
			return;
		mag = s[SAMPLE_W-1] ? MAG_W'(~s + 1'b1) : MAG_W'(s);
		if (mag > peak_hold[ch])
			peak_hold[ch] = mag;
		fill[ch] = fill[ch] + 1'b1;
		len = (cfg_len == '0) ? LEN_W'(1) : cfg_len;
		if (fill[ch] < len)
			return;
		rec.ch    = ch;
		rec.peak  = peak_hold[ch];
		rec.start = elapsed[ch];
		rec.unit  = cfg_rate;
		rec.len   = len;
		frames_due.push_back(rec);
		elapsed[ch]   = elapsed[ch] + len;
		peak_hold[ch] = '0;
		fill[ch]      = '0;
	endtask

	always @(posedge clk) begin
		frame_rec_t want;
		smp_taken <= arst_n && smp.valid && smp.ready;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				apply_write(cfg.index, cfg.data);
			if (smp.valid && smp.ready)
				predict_sample(smp.channel, smp.sample);
			if (res.valid && res.ready) begin
				if (frames_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result on channel %0d, peak %0d",
						res.out_channel, res.peak));
				end else begin
					want = frames_due.pop_front();
					results_seen++;
					if (res.out_channel !== want.ch)
						flag_mismatch($sformatf("out_channel %0d, expected %0d",
							res.out_channel, want.ch));
					if (res.peak !== want.peak)
						flag_mismatch($sformatf("peak %0d, expected %0d", res.peak, want.peak));
					if (res.start_time !== want.start)
						flag_mismatch($sformatf("start_time %0d, expected %0d",
							res.start_time, want.start));
					if (res.time_unit !== want.unit)
						flag_mismatch($sformatf("time_unit %0d, expected %0d",
							res.time_unit, want.unit));
					if (res.frame_length !== want.len)
						flag_mismatch($sformatf("frame_length %0d, expected %0d",
							res.frame_length, want.len));
				end
			end
		end
	end

	always @(negedge clk) begin
		pcm_item_t nxt;
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else if (!smp.valid || smp_taken) begin
			if (smp_gap != 0) begin
				smp_gap   <= smp_gap - 1;
				smp.valid <= 1'b0;
			end else if (pend.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
				smp_gap   <= $urandom_range(0, 18);
				smp.valid <= 1'b0;
			end else if (pend.size() != 0) begin
				nxt = pend.pop_front();
				smp.valid   <= 1'b1;
				smp.channel <= nxt.ch;
				smp.sample  <= nxt.s;
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (res_stall != 0) begin
			res_stall <= res_stall - 1;
			res.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			res_stall <= $urandom_range(0, 18);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		writes_done++;
	endtask

	task automatic send(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		pcm_item_t it;
		it.ch = ch;
		it.s  = s;
		pend.push_back(it);
		items_sent++;
	endtask

	task automatic settle();
		do @(posedge clk); while (pend.size() != 0 || smp.valid || frames_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned       r;
		int                n;
		logic [LEN_W-1:0]  len_val;
		logic [RATE_W-1:0] rate_val;
		logic [CIU_W-1:0]  ciu_val;
		arst_n      = 1'b0;
		smp.valid   = 1'b0;
		smp.channel = '0;
		smp.sample  = '0;
		res.ready   = 1'b0;
		cfg.valid   = 1'b0;
		cfg.index   = REG_RUN_ENABLE;
		cfg.data    = '0;
		clear_progress();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Stopped after reset, so these items are dropped.
		send(1'b0, -16'sd5);
		send(1'b1, 16'sd100);
		settle();

		// One-sample frames under the reset sample rate.
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(1));
		write_reg(REG_RUN_ENABLE, CFG_DATA_W'(1));
		send(1'b0, 16'h8000);
		send(1'b1, 16'h7FFF);
		send(1'b0, 16'h0000);
		send(1'b1, 16'hFFFF);
		send(1'b0, 16'h0001);
		send(1'b1, 16'h8001);
		settle();

		// A zero frame length behaves as one; channel 1 is inactive.
		write_reg(REG_SAMPLE_RATE, '0);
		write_reg(REG_FRAME_SAMPLES, {2'b11, 16'h0000});
		write_reg(REG_CHANNELS_IN_USE, CFG_DATA_W'(1));
		send(1'b0, 16'd1234);
		send(1'b1, -16'sd2);
		send(1'b0, -16'sd300);
		settle();

		write_reg(REG_SAMPLE_RATE, {RATE_W{1'b1}});
		write_reg(REG_CHANNELS_IN_USE, CFG_DATA_W'(0));
		send(1'b0, 16'd5);
		send(1'b1, 16'd5);
		settle();
		write_reg(REG_CHANNELS_IN_USE, {16'hFFFF, 2'd3});
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(2));
		send(1'b1, -16'sd7);
		send(1'b1, 16'sd3);
		send(1'b0, 16'sd9);
		settle();

		// Shortening the frame below the partial count closes it on the next sample.
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(20));
		write_reg(REG_RUN_ENABLE, {17'h1FFFF, 1'b1});
		for (int i = 0; i < 5; i++)
			send(1'b0, SAMPLE_W'(i * 1000 - 2500));
		settle();
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(3));
		send(1'b0, -16'sd40);
		settle();

		write_reg(REG_RUN_ENABLE, {17'h1FFFF, 1'b0});
		send(1'b1, 16'h8000);
		settle();
		write_reg(REG_RUN_ENABLE, CFG_DATA_W'(1));

		while (items_sent < 520) begin
			settle();
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 9);
				len_val = (r == 0) ? LEN_W'(0) :
					(r == 1) ? LEN_W'($urandom_range(17, 300)) : LEN_W'($urandom_range(1, 16));
				write_reg(REG_FRAME_SAMPLES, {2'($urandom), len_val});
			end
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 9);
				rate_val = (r == 0) ? RATE_W'(0) : (r == 1) ? {RATE_W{1'b1}} :
					(r == 2) ? RATE_W'(192000) : RATE_W'($urandom_range(1, 192000));
				write_reg(REG_SAMPLE_RATE, rate_val);
			end
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 9);
				ciu_val = (r == 0) ? CIU_W'(0) : (r == 1) ? CIU_W'(3) :
					(r < 6) ? CIU_W'(1) : CIU_W'(2);
				write_reg(REG_CHANNELS_IN_USE, {16'($urandom), ciu_val});
			end
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_RUN_ENABLE, {17'($urandom), ($urandom_range(0, 4) != 0)});
			n = $urandom_range(10, 60);
			for (int i = 0; i < n; i++)
				send(CH_W'($urandom), pick_sample());
		end

		// A partial frame at the longest length, followed by dropped samples on the inactive
		// channel, closed by lowering the length.
		settle();
		idle_on = 1'b1;
		write_reg(REG_FRAME_SAMPLES, {2'b10, 16'hFFFF});
		write_reg(REG_CHANNELS_IN_USE, CFG_DATA_W'(1));
		write_reg(REG_RUN_ENABLE, CFG_DATA_W'(1));
		for (int i = 0; i < 40; i++)
			send(1'b0, pick_sample());
		for (int i = 0; i < 20; i++)
			send(1'b1, pick_sample());
		settle();
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(7));
		send(1'b0, pick_sample());
		settle();

		idle_on = 1'b0;
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(5));
		write_reg(REG_CHANNELS_IN_USE, CFG_DATA_W'(2));
		write_reg(REG_RUN_ENABLE, CFG_DATA_W'(1));
		for (int i = 0; i < 200; i++)
			send(CH_W'($urandom), pick_sample());
		settle();

		$display("Sent %0d samples over %0d register writes; %0d frame results checked",
			items_sent, writes_done, results_seen);
		$display("Frame lengths from 0 to 300, a cut-short longest frame, full-scale peaks; %0d mismatches",
			errors);
		if (errors == 0 && frames_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
